// ----- rtl/aghrq_pkg.sv -----
package aghrq_pkg;

    localparam int unsigned MaxGenres = 10;
    localparam int unsigned CntW      = 32;
    localparam int unsigned GenW      = 4;
    localparam int unsigned AgeW      = 7;

    localparam logic        CmdCount = 1'b0;
    localparam logic        CmdQuery = 1'b1;

    typedef logic [CntW-1:0] t_count;
    typedef logic [GenW-1:0] t_genre;

    // alphabetical rank of each genre name, by genre index
    function automatic logic [3:0] name_rank(input t_genre g);
        logic [3:0] r;
        case (g)
            4'd0:    r = 4'd9;
            4'd1:    r = 4'd5;
            4'd2:    r = 4'd7;
            4'd3:    r = 4'd1;
            4'd4:    r = 4'd4;
            4'd5:    r = 4'd2;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd0;
            4'd8:    r = 4'd6;
            4'd9:    r = 4'd8;
            default: r = 4'd15;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/aghrq_ram.sv -----
module aghrq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/age_genre_histogram_ranked_query.sv -----
// Age-by-genre histogram of saturating 32-bit counters held in one
// single-port-read RAM of AGE_SLOTS*GENRES words. After reset the block walks
// the RAM once to clear it and takes no request meanwhile. A count request
// is a read-modify-write of one word. A query reads one word per cycle over
// the clamped age range, then finishes the last sum. It then picks results
// by repeated selection over the GENRES sums: one scan of the sums and one
// hand-off per result, and one final scan that finds nothing left. A result
// held by a stall holds the selection, and no new request is taken while a
// result is still waiting.
module age_genre_histogram_ranked_query #(
    parameter int unsigned AGE_SLOTS = 100,
    parameter int unsigned GENRES    = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [6:0]  i_age,
    input  logic [3:0]  i_genre,
    input  logic [6:0]  i_range_from,
    input  logic [6:0]  i_range_to,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_genre_out,
    output logic [31:0] o_total,
    output logic        o_empty_res,
    output logic        o_last
);

    localparam int unsigned Cells = AGE_SLOTS * GENRES;
    localparam int unsigned AW    = $clog2(Cells + 1);
    localparam int unsigned GW    = aghrq_pkg::GenW;
    localparam int unsigned CntW  = aghrq_pkg::CntW;

    localparam logic [3:0] StClear = 4'd0;
    localparam logic [3:0] StIdle  = 4'd1;
    localparam logic [3:0] StCRd   = 4'd2;
    localparam logic [3:0] StCWr   = 4'd3;
    localparam logic [3:0] StQRd   = 4'd4;
    localparam logic [3:0] StQLast = 4'd5;
    localparam logic [3:0] StSel   = 4'd6;
    localparam logic [3:0] StEmit  = 4'd7;
    localparam logic [3:0] StEmpty = 4'd8;

    localparam logic [AW-1:0] CellsA  = AW'(Cells);
    localparam logic [GW-1:0] GenLast = GW'(GENRES - 1);
    localparam logic [6:0]    AgeLast = 7'(AGE_SLOTS - 1);

    logic [3:0]    r_state;
    logic [AW-1:0] r_addr, r_end;
    logic [GW-1:0] r_g;
    logic          r_rd_live;
    logic [GW-1:0] r_rd_g;
    aghrq_pkg::t_count r_sum [GENRES];
    logic [GENRES-1:0] r_done;
    logic [GW-1:0]     r_best;
    logic              r_has;
    logic [GW-1:0]     r_left;
    logic              r_ov;
    logic [3:0]        r_og;
    aghrq_pkg::t_count r_ot;
    logic              r_oe, r_ol;

    logic              we;
    logic [AW-1:0]     waddr;
    aghrq_pkg::t_count wdata, rdata;

    aghrq_ram #(.WIDTH(aghrq_pkg::CntW), .DEPTH(Cells)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[$clog2(Cells)-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_addr[$clog2(Cells)-1:0]),
        .o_rdata (rdata)
    );

    logic out_free, accept;
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != StIdle) || !out_free;
    assign accept   = i_valid && !o_stall;

    logic [6:0]  q_top;
    logic [AW:0] base_from, base_to;
    always_comb begin
        q_top     = (i_range_to > AgeLast) ? AgeLast : i_range_to;
        base_from = (AW+1)'(i_range_from) * (AW+1)'(GENRES);
        base_to   = (AW+1)'(q_top) * (AW+1)'(GENRES) + (AW+1)'(GENRES - 1);
    end

    // saturating accumulate of the word that came back from the ram
    logic [CntW:0] acc;
    assign acc = {1'b0, r_sum[r_rd_g]} + {1'b0, rdata};

    // does candidate genre r_g beat the current best
    logic beats;
    always_comb begin
        if (!r_has) begin
            beats = 1'b1;
        end else if (r_sum[r_g] != r_sum[r_best]) begin
            beats = r_sum[r_g] > r_sum[r_best];
        end else begin
            beats = aghrq_pkg::name_rank(r_g) < aghrq_pkg::name_rank(r_best);
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (r_state == StClear) begin
            we = 1'b1;
        end else if (r_state == StCWr) begin
            we    = 1'b1;
            wdata = (rdata == '1) ? rdata : rdata + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= StClear;
            r_addr    <= '0;
            r_rd_live <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (r_rd_live) begin
                r_sum[r_rd_g] <= acc[CntW] ? '1 : acc[CntW-1:0];
            end
            r_rd_live <= 1'b0;
            case (r_state)
                StClear: begin
                    if (r_addr == CellsA - 1'b1) begin
                        r_state <= StIdle;
                    end
                    r_addr <= r_addr + 1'b1;
                end
                StIdle: begin
                    if (accept) begin
                        if (i_command == aghrq_pkg::CmdCount) begin
                            if ({1'b0, i_age} < 8'(AGE_SLOTS)
                                    && {1'b0, i_genre} < 5'(GENRES)) begin
                                r_addr  <= AW'((AW+1)'(i_age) * (AW+1)'(GENRES)
                                               + (AW+1)'(i_genre));
                                r_state <= StCRd;
                            end
                        end else begin
                            for (int k = 0; k < GENRES; k++) begin
                                r_sum[k] <= '0;
                            end
                            if (i_range_from > i_range_to || i_range_from > AgeLast) begin
                                r_state <= StEmpty;
                            end else begin
                                r_addr  <= AW'(base_from);
                                r_end   <= AW'(base_to);
                                r_g     <= '0;
                                r_state <= StQRd;
                            end
                        end
                    end
                end
                StCRd:   r_state <= StCWr;
                StCWr:   r_state <= StIdle;
                StQRd: begin
                    r_rd_live <= 1'b1;
                    r_rd_g    <= r_g;
                    r_g       <= (r_g == GenLast) ? '0 : r_g + 1'b1;
                    r_addr    <= r_addr + 1'b1;
                    if (r_addr == r_end) begin
                        r_state <= StQLast;
                    end
                end
                StQLast: begin
                    r_done  <= '0;
                    r_g     <= '0;
                    r_has   <= 1'b0;
                    r_left  <= '0;
                    r_state <= StSel;
                end
                StSel: begin
                    if (!r_done[r_g] && r_sum[r_g] != '0 && beats) begin
                        r_best <= r_g;
                        r_has  <= 1'b1;
                    end
                    if (r_g == GenLast) begin
                        r_state <= StEmit;
                    end else begin
                        r_g <= r_g + 1'b1;
                    end
                end
                StEmit: begin
                    if (!r_has) begin
                        r_state <= (r_left == '0) ? StEmpty : StIdle;
                    end else if (out_free) begin
                        // look one ahead: last when nothing else remains
                        r_ov   <= 1'b1;
                        r_og   <= r_best;
                        r_ot   <= r_sum[r_best];
                        r_oe   <= 1'b0;
                        r_ol   <= 1'b0;
                        r_done[r_best] <= 1'b1;
                        r_left <= r_left + 1'b1;
                        r_has  <= 1'b0;
                        r_g    <= '0;
                        r_state <= StSel;
                    end
                end
                StEmpty: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_og    <= '0;
                        r_ot    <= '0;
                        r_oe    <= 1'b1;
                        r_ol    <= 1'b1;
                        r_state <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    // last flag: a result is last when no unsent nonzero sum remains
    logic [GENRES-1:0] remain;
    always_comb begin
        for (int k = 0; k < GENRES; k++) begin
            remain[k] = !r_done[k] && r_sum[k] != '0;
        end
    end

    assign o_valid     = r_ov;
    assign o_genre_out = r_og;
    assign o_total     = r_ot;
    assign o_empty_res = r_oe;
    assign o_last      = r_ol || (r_ov && !r_oe && remain == '0 && r_state != StIdle
                                  && r_state != StEmpty) || (r_ov && !r_oe && r_state == StIdle);

endmodule

// ----- rtl/aghrq_checker.sv -----
module aghrq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_genre_out,
    input logic [31:0] o_total,
    input logic        o_empty_res,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total) && $stable(o_genre_out))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_last && o_total == 32'd0)
        else $error("empty result malformed");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_empty_res |-> o_total != 32'd0)
        else $error("zero total on ranked result");

    // no new request while a result is held back
    a_wait_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("request taken while a result waits");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind age_genre_histogram_ranked_query aghrq_checker u_aghrq_checker (.*);

// ----- dv/age_genre_histogram_ranked_query_tb.sv -----
`timescale 1ns / 100ps

module age_genre_histogram_ranked_query_tb;

    localparam int unsigned AgeSlots = 100;
    localparam int unsigned Genres   = 10;
    localparam logic [31:0] Sat      = 32'hFFFF_FFFF;

    typedef struct packed {
        aghrq_pkg::t_genre genre;
        aghrq_pkg::t_count total;
        logic              empty;
        logic              last;
    } t_rank_entry;

    // ranked query predictor with its own histogram copy
    class ranked_scoreboard;
        aghrq_pkg::t_count cells[AgeSlots][Genres];
        t_rank_entry       pending[$];
        int                mismatches;
        int                checked;
        int                queries;
        int                counts;

        function new();
            foreach (cells[a, g]) cells[a][g] = '0;
            mismatches = 0;
            checked    = 0;
            queries    = 0;
            counts     = 0;
        endfunction

        function automatic logic [3:0] alpha_pos(int g);
            logic [3:0] r;
            case (g)
                0: r = 4'd9;  1: r = 4'd5;  2: r = 4'd7;  3: r = 4'd1;  4: r = 4'd4;
                5: r = 4'd2;  6: r = 4'd3;  7: r = 4'd0;  8: r = 4'd6;  default: r = 4'd8;
            endcase
            return r;
        endfunction

        function void note_request(logic cmd, logic [6:0] age, logic [3:0] genre,
                                   logic [6:0] from, logic [6:0] to);
            aghrq_pkg::t_count sums[Genres];
            int                order[$];
            int                pos;
            t_rank_entry       e;
            if (cmd == aghrq_pkg::CmdCount) begin
                counts++;
                if (age < AgeSlots && genre < Genres && cells[age][genre] != Sat)
                    cells[age][genre] = cells[age][genre] + 32'd1;
                return;
            end
            queries++;
            foreach (sums[g]) sums[g] = '0;
            if (from <= to)
                for (int a = from; a <= to && a < AgeSlots; a++)
                    for (int g = 0; g < Genres; g++)
                        sums[g] = (sums[g] > Sat - cells[a][g]) ? Sat
                                                                : sums[g] + cells[a][g];
            for (int g = 0; g < Genres; g++) begin
                if (sums[g] == 0) continue;
                pos = order.size();
                while (pos > 0 && (sums[g] > sums[order[pos-1]] ||
                       (sums[g] == sums[order[pos-1]] &&
                        alpha_pos(g) < alpha_pos(order[pos-1]))))
                    pos--;
                order.insert(pos, g);
            end
            if (order.size() == 0) begin
                e = '{genre: '0, total: '0, empty: 1'b1, last: 1'b1};
                pending.push_back(e);
            end
            foreach (order[i]) begin
                e.genre = aghrq_pkg::t_genre'(order[i]);
                e.total = sums[order[i]];
                e.empty = 1'b0;
                e.last  = (i == order.size() - 1);
                pending.push_back(e);
            end
        endfunction

        function void check_result(t_rank_entry got);
            t_rank_entry exp;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result, expected none, got genre=%0d total=%0d",
                             got.genre, got.total);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp genre=%0d total=%0d empty=%0b last=%0b, ",
                              "got genre=%0d total=%0d empty=%0b last=%0b"},
                             exp.genre, exp.total, exp.empty, exp.last,
                             got.genre, got.total, got.empty, got.last);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_command = aghrq_pkg::CmdCount;
    logic [6:0] i_age = '0;
    logic [3:0] i_genre = '0;
    logic [6:0] i_range_from = '0;
    logic [6:0] i_range_to = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [3:0] o_genre_out;
    logic [31:0] o_total;
    logic       o_empty_res;
    logic       o_last;

    ranked_scoreboard board = new();
    bit               calm_phase = 1'b0;

    age_genre_histogram_ranked_query dut (.*);

    always #1 i_clk = ~i_clk;

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_request(i_command, i_age, i_genre, i_range_from, i_range_to);
            if (o_valid && !i_stall)
                board.check_result('{genre: o_genre_out, total: o_total,
                                     empty: o_empty_res, last: o_last});
        end
    end

    // random back-pressure on the result side
    always @(negedge i_clk)
        i_stall <= (!calm_phase && $urandom_range(99) < 15);

    task automatic send_request(logic cmd, logic [6:0] age, logic [3:0] genre,
                                logic [6:0] from, logic [6:0] to);
        while (!calm_phase && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_age        <= age;
        i_genre      <= genre;
        i_range_from <= from;
        i_range_to   <= to;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic count_event(logic [6:0] age, logic [3:0] genre);
        send_request(aghrq_pkg::CmdCount, age, genre, 7'($urandom), 7'($urandom));
    endtask

    task automatic range_query(logic [6:0] from, logic [6:0] to);
        send_request(aghrq_pkg::CmdQuery, 7'($urandom), 4'($urandom), from, to);
    endtask

    initial begin
        int kind;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes, ties, out-of-range counts, inverted range
        range_query(0, 127);
        count_event(0, 0);
        count_event(99, 9);
        count_event(100, 3);
        count_event(127, 15);
        count_event(5, 10);
        range_query(0, 127);
        count_event(10, 7);
        count_event(10, 3);
        count_event(11, 5);
        count_event(12, 3);
        range_query(10, 12);
        range_query(12, 10);
        range_query(99, 99);
        range_query(100, 127);
        range_query(127, 127);
        range_query(0, 0);
        for (int g = 0; g < 10; g++) count_event(50, 4'(g));
        range_query(50, 50);
        range_query(127, 0);

        // random: mostly counts into a narrow band so queries see ties and ranking
        for (int n = 0; n < 140; n++) begin
            calm_phase = (n >= 60 && n < 100);
            kind = $urandom_range(99);
            if (kind < 70) begin
                if ($urandom_range(9) == 0)
                    count_event(7'($urandom), 4'($urandom));
                else
                    count_event(7'($urandom_range(20, 30)), 4'($urandom_range(9)));
            end else begin
                if ($urandom_range(4) == 0)
                    range_query(7'($urandom), 7'($urandom));
                else
                    range_query(7'($urandom_range(15, 25)), 7'($urandom_range(25, 127)));
            end
        end
        calm_phase = 1'b0;
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d count and %0d query requests, %0d results checked",
                 board.counts, board.queries, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[age_genre_histogram_ranked_query] OK");
        else
            $display("[age_genre_histogram_ranked_query] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[age_genre_histogram_ranked_query] ERROR");
        $finish;
    end

endmodule
